### hdl/ghe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ghe_pkg;

	// coordinate format
	localparam int FRACTION_BITS  = 32;
	localparam int LAT_W          = FRACTION_BITS + 8;
	localparam int LON_W          = FRACTION_BITS + 9;

	// hash format
	localparam int MAX_HASH_CHARS = 12;
	localparam int LEN_W          = 4;
	localparam int CHAR_W         = 7;
	localparam int CHAR_BITS      = 5;

	// each coordinate resolves to 30 bisection bits: the span of 180 or 360 degrees
	// is 45 times a power of two, so the cell index is offset / (45 << shift)
	localparam int QUOT_BITS      = 30;
	localparam int HASH_BITS      = 2 * QUOT_BITS;
	localparam int CELL_DIVISOR   = 45;
	localparam int LAT_SHIFT      = FRACTION_BITS - 28;
	localparam int LON_SHIFT      = FRACTION_BITS - 27;
	localparam int DIV_W          = LAT_W - LAT_SHIFT;
	localparam int REM_W          = $clog2(CELL_DIVISOR);
	localparam int STEPS_PER_CYCLE = 6;
	localparam int DIV_CYCLES     = DIV_W / STEPS_PER_CYCLE;
	localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

	// job queue between front and back
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [LAT_W-1:0] LAT_LIMIT = LAT_W'(90) << FRACTION_BITS;
	localparam logic signed [LON_W-1:0] LON_LIMIT = LON_W'(180) << FRACTION_BITS;

	localparam logic [CHAR_W-1:0] BASE32 [0:31] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
		7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
		7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
	};

	typedef struct packed {
		logic [DIV_W-1:0] lon_div;
		logic [DIV_W-1:0] lat_div;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic [HASH_BITS-1:0] bits;
		logic [LEN_W-1:0]     len;
	} cell_t;

endpackage

`default_nettype wire

### hdl/ghe_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ghe_coord_if import ghe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] latitude;
	logic signed [LON_W-1:0] longitude;
	logic [LEN_W-1:0]        hash_length;

	modport source (output valid, output latitude, output longitude, output hash_length,
		input ready);
	modport sink (input valid, input latitude, input longitude, input hash_length,
		output ready);
endinterface

interface ghe_hash_if import ghe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] hash_char;
	logic              last_char;

	modport source (output valid, output hash_char, output last_char, input ready);
	modport sink (input valid, input hash_char, input last_char, output ready);
endinterface

`default_nettype wire

### hdl/geohash_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// geohash encoder: takes one latitude/longitude pair in signed degrees with 32 fractional
// bits plus a hash length, and returns the geohash as a stream of base-32 ascii characters,
// one transaction per character, with last_char set on the final one. coordinates outside
// the globe are saturated, a length of zero counts as one and lengths above twelve as twelve.
// the front saturates the transaction and turns each coordinate into an offset from its lower
// bound; a two-entry job queue decouples it from the back end. the back end finds each cell
// index as offset / (45 * 2^k) with a restoring divider that makes six quotient bits per cycle
// for both coordinates at once; a job goes through load, the division steps and a hand-off that
// waits for the emitter. the emitter then sends one character per cycle while the output is not
// stalled, and its hash overlaps with the division of the next job. there is no configuration
// and no state carries over from one pair to the next.

module geohash_encoder_core import ghe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ghe_coord_if.sink  coord,
	ghe_hash_if.source hash
);

	// front to queue
	logic  push;
	logic  q_ready;
	job_t  push_job;

	// queue to divider
	logic  job_valid;
	logic  job_pop;
	job_t  job;

	// divider to emitter
	logic  res_valid;
	logic  res_ready;
	cell_t res;

	// saturation, offsets and length clamp
	ghe_front u_front (
		.coord   (coord),
		.q_ready (q_ready),
		.push    (push),
		.job     (push_job)
	);

	// short queue so the front keeps taking pairs while the back end works
	ghe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.ready     (q_ready),
		.job_valid (job_valid),
		.job       (job),
		.pop       (job_pop)
	);

	// cell indices by constant division, interleaved into the hash bits
	ghe_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// character lookup and output register
	ghe_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.hash      (hash)
	);

endmodule

`default_nettype wire

### hdl/ghe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ghe_front import ghe_pkg::*; (
	ghe_coord_if.sink  coord,
	input  logic       q_ready,
	output logic       push,
	output job_t       job
);

	logic signed [LAT_W-1:0] lat_c;
	logic signed [LON_W-1:0] lon_c;
	logic [LAT_W-1:0]        lat_off;
	logic [LON_W-1:0]        lon_off;

	assign coord.ready = q_ready;
	assign push        = coord.valid && q_ready;

	// saturate to the globe
	always_comb begin
		if (coord.latitude < -LAT_LIMIT)
			lat_c = -LAT_LIMIT;
		else if (coord.latitude > LAT_LIMIT)
			lat_c = LAT_LIMIT;
		else
			lat_c = coord.latitude;

		if (coord.longitude < -LON_LIMIT)
			lon_c = -LON_LIMIT;
		else if (coord.longitude > LON_LIMIT)
			lon_c = LON_LIMIT;
		else
			lon_c = coord.longitude;
	end

	// offsets from the lower bound, never negative
	assign lat_off = lat_c + LAT_LIMIT;
	assign lon_off = lon_c + LON_LIMIT;

	always_comb begin
		job.lat_div = lat_off[LAT_W-1:LAT_SHIFT];
		job.lon_div = lon_off[LON_W-1:LON_SHIFT];
		if (coord.hash_length == '0)
			job.len = LEN_W'(1);
		else if (coord.hash_length > LEN_W'(MAX_HASH_CHARS))
			job.len = LEN_W'(MAX_HASH_CHARS);
		else
			job.len = coord.hash_length;
	end

endmodule

`default_nettype wire

### hdl/ghe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ghe_queue import ghe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic ready,
	output logic job_valid,
	output job_t job,
	input  logic pop
);

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign ready     = count_q != QCNT_W'(QUEUE_DEPTH);
	assign job_valid = count_q != '0;
	assign job       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### hdl/ghe_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module ghe_divider import ghe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  job_valid,
	input  job_t  job,
	output logic  job_pop,
	output logic  res_valid,
	output cell_t res,
	input  logic  res_ready
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} div_state_t;

	div_state_t             state_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]       lon_dvd_q, lat_dvd_q;
	logic [DIV_W-1:0]       lon_quot_q, lat_quot_q;
	logic [REM_W-1:0]       lon_rem_q, lat_rem_q;
	logic [LEN_W-1:0]       len_q;

	logic [REM_W-1:0]           lon_rem_d, lat_rem_d;
	logic [STEPS_PER_CYCLE-1:0] lon_qbits, lat_qbits;
	logic [QUOT_BITS-1:0]       lon_cell, lat_cell;

	// one restoring step by the cell divisor
	function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem, logic din);
		logic [REM_W:0] t;
		t = {rem, din};
		if (t >= (REM_W+1)'(CELL_DIVISOR))
			return {1'b1, REM_W'(t - (REM_W+1)'(CELL_DIVISOR))};
		else
			return {1'b0, t[REM_W-1:0]};
	endfunction

	// a few quotient bits per cycle, msb first, both coordinates side by side
	always_comb begin
		logic [REM_W:0] st;
		lon_rem_d = lon_rem_q;
		lat_rem_d = lat_rem_q;
		for (int j = 0; j < STEPS_PER_CYCLE; j++) begin
			st = div_step(lon_rem_d, lon_dvd_q[DIV_W-1-j]);
			lon_rem_d = st[REM_W-1:0];
			lon_qbits[STEPS_PER_CYCLE-1-j] = st[REM_W];
			st = div_step(lat_rem_d, lat_dvd_q[DIV_W-1-j]);
			lat_rem_d = st[REM_W-1:0];
			lat_qbits[STEPS_PER_CYCLE-1-j] = st[REM_W];
		end
	end

	// a coordinate on the upper bound lands in the topmost cell
	assign lon_cell = (|lon_quot_q[DIV_W-1:QUOT_BITS]) ? '1 : lon_quot_q[QUOT_BITS-1:0];
	assign lat_cell = (|lat_quot_q[DIV_W-1:QUOT_BITS]) ? '1 : lat_quot_q[QUOT_BITS-1:0];

	// interleave, longitude first
	always_comb begin
		for (int i = 0; i < QUOT_BITS; i++) begin
			res.bits[2*i+1] = lon_cell[i];
			res.bits[2*i]   = lat_cell[i];
		end
		res.len = len_q;
	end

	assign job_pop   = (state_q == IDLE) && job_valid;
	assign res_valid = (state_q == DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (job_valid) begin
						lon_dvd_q <= job.lon_div;
						lat_dvd_q <= job.lat_div;
						lon_rem_q <= '0;
						lat_rem_q <= '0;
						len_q     <= job.len;
						cnt_q     <= '0;
						state_q   <= RUN;
					end
				end
				RUN: begin
					lon_dvd_q  <= lon_dvd_q << STEPS_PER_CYCLE;
					lat_dvd_q  <= lat_dvd_q << STEPS_PER_CYCLE;
					lon_quot_q <= {lon_quot_q[DIV_W-STEPS_PER_CYCLE-1:0], lon_qbits};
					lat_quot_q <= {lat_quot_q[DIV_W-STEPS_PER_CYCLE-1:0], lat_qbits};
					lon_rem_q  <= lon_rem_d;
					lat_rem_q  <= lat_rem_d;
					cnt_q      <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1))
						state_q <= DONE;
				end
				DONE: begin
					if (res_ready)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/ghe_emitter.sv
`timescale 1ns / 1ps
`default_nettype none

module ghe_emitter import ghe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  cell_t      res,
	output logic       res_ready,
	ghe_hash_if.source hash
);

	logic                 busy_q;
	logic [HASH_BITS-1:0] bits_q;
	logic [LEN_W-1:0]     left_q;
	logic                 valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic                 advance;

	assign res_ready      = !busy_q;
	assign advance        = !valid_q || hash.ready;
	assign hash.valid     = valid_q;
	assign hash.hash_char = char_q;
	assign hash.last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			left_q  <= '0;
		end else begin
			if (advance) begin
				if (busy_q) begin
					valid_q <= 1'b1;
					char_q  <= BASE32[bits_q[HASH_BITS-1 -: CHAR_BITS]];
					last_q  <= (left_q == LEN_W'(1));
					bits_q  <= bits_q << CHAR_BITS;
					left_q  <= left_q - LEN_W'(1);
					if (left_q == LEN_W'(1))
						busy_q <= 1'b0;
				end else begin
					valid_q <= 1'b0;
				end
			end
			if (!busy_q && res_valid) begin
				busy_q <= 1'b1;
				bits_q <= res.bits;
				left_q <= res.len;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/ghe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ghe_checker import ghe_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              hash_valid,
	input logic              hash_ready,
	input logic [CHAR_W-1:0] hash_char,
	input logic              last_char
);

	// a stalled character stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> hash_valid && $stable(hash_char) && $stable(last_char))
		else $error("stalled character changed or dropped");

	// only geohash alphabet characters leave the block
	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid |-> (hash_char >= 7'h30 && hash_char <= 7'h39) ||
			(hash_char >= 7'h62 && hash_char <= 7'h7a && hash_char != 7'h69 &&
			hash_char != 7'h6c && hash_char != 7'h6f))
		else $error("character outside the base-32 alphabet");

	// an offered character is fully defined
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid |-> !$isunknown({hash_char, last_char}))
		else $error("offered character has unknown bits");

endmodule

bind geohash_encoder_core ghe_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.hash_valid (hash.valid),
	.hash_ready (hash.ready),
	.hash_char  (hash.hash_char),
	.last_char  (hash.last_char)
);

`default_nettype wire

### tb/geohash_checker.sv
`timescale 1ns / 1ps

module geohash_checker import ghe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ghe_coord_if coord,
	ghe_hash_if  hash,
	output int   errors,
	output int   pending,
	output int   pairs,
	output int   chars
);

	localparam longint LAT_MAX = longint'(LAT_LIMIT);
	localparam longint LON_MAX = longint'(LON_LIMIT);

	// base-32 digits, first digit in the top byte
	localparam logic [8*32-1:0] DIGITS = "0123456789bcdefghjkmnpqrstuvwxyz";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} hash_char_t;

	hash_char_t expected_chars [$];
	hash_char_t head;
	int         err_n   = 0;
	int         pairs_n = 0;
	int         chars_n = 0;

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_n++;
	endtask

	// bisect both intervals, longitude first, and queue one entry per character
	function automatic void encode_pair(input logic signed [LAT_W-1:0] lat_in,
		input logic signed [LON_W-1:0] lon_in, input logic [LEN_W-1:0] len_in);
		longint               lat, lon, lat_lo, lat_hi, lon_lo, lon_hi, mid;
		int                   n_chars, c, b;
		logic [CHAR_BITS-1:0] code;
		logic                 lon_turn, bit_v;
		hash_char_t           entry;
		lat = longint'(lat_in);
		lon = longint'(lon_in);
		if (lat < -LAT_MAX) lat = -LAT_MAX;
		if (lat > LAT_MAX) lat = LAT_MAX;
		if (lon < -LON_MAX) lon = -LON_MAX;
		if (lon > LON_MAX) lon = LON_MAX;
		n_chars = int'(len_in);
		if (n_chars < 1) n_chars = 1;
		if (n_chars > MAX_HASH_CHARS) n_chars = MAX_HASH_CHARS;
		lat_lo   = -LAT_MAX;
		lat_hi   = LAT_MAX;
		lon_lo   = -LON_MAX;
		lon_hi   = LON_MAX;
		lon_turn = 1'b1;
		for (c = 0; c < n_chars; c++) begin
			code = '0;
			for (b = 0; b < CHAR_BITS; b++) begin
				if (lon_turn) begin
					mid   = lon_lo + ((lon_hi - lon_lo) >>> 1);
					bit_v = (lon >= mid);
					if (bit_v) lon_lo = mid;
					else lon_hi = mid;
				end else begin
					mid   = lat_lo + ((lat_hi - lat_lo) >>> 1);
					bit_v = (lat >= mid);
					if (bit_v) lat_lo = mid;
					else lat_hi = mid;
				end
				lon_turn = !lon_turn;
				code     = {code[CHAR_BITS-2:0], bit_v};
			end
			entry.ch   = DIGITS[8*(31-int'(code)) +: CHAR_W];
			entry.last = (c == n_chars - 1);
			expected_chars = {expected_chars, entry};
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (hash.valid && hash.ready) begin
				chars_n++;
				if (expected_chars.size() == 0) begin
					report($sformatf("character 0x%02h with nothing expected", hash.hash_char));
				end else begin
					head = expected_chars.pop_front();
					if (hash.hash_char !== head.ch)
						report($sformatf("hash_char 0x%02h, expected 0x%02h",
							hash.hash_char, head.ch));
					if (hash.last_char !== head.last)
						report($sformatf("last_char %b, expected %b",
							hash.last_char, head.last));
				end
			end
			if (coord.valid && coord.ready) begin
				pairs_n++;
				encode_pair(coord.latitude, coord.longitude, coord.hash_length);
			end
		end
		errors  <= err_n;
		pending <= expected_chars.size();
		pairs   <= pairs_n;
		chars   <= chars_n;
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ghe_pkg::*;

	// coordinate limits as plain 64-bit numbers
	localparam longint LAT_MAX      = longint'(LAT_LIMIT);
	localparam longint LON_MAX      = longint'(LON_LIMIT);
	localparam int     RANDOM_PAIRS = 200;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     HOLD_AFTER   = 60;
	localparam int     DRAIN_CYCLES = 40;
	localparam longint CYCLE_LIMIT  = 200000;

	// receiver behavior, picked anew for each random span
	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_BEAT
	} sink_mode_t;

	logic   clk = 1'b0;
	logic   arst_n;
	int     errors, pending, pairs, chars;
	int     burst_left;
	longint cycle_count = 0;

	ghe_coord_if coord_ch ();
	ghe_hash_if  hash_ch ();

	geohash_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coord  (coord_ch),
		.hash   (hash_ch)
	);

	// the checker follows both channels and owns all prediction
	geohash_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.coord   (coord_ch),
		.hash    (hash_ch),
		.errors  (errors),
		.pending (pending),
		.pairs   (pairs),
		.chars   (chars)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still expected",
				cycle_count, pending);
			$display("FAIL");
			$finish;
		end
	end

	// one coordinate: mostly uniform over the globe, some on cell edges,
	// some raw bit patterns (out of range, all bits toggling), some exact poles
	function automatic longint pick_coord(input longint limit);
		longint unsigned r;
		int              pick, n;
		longint          step_sz, k;
		r    = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return longint'(r % longint'(2 * limit + 1)) - limit;
		end else if (pick < 85) begin
			// a cell boundary at depth n, nudged by one lsb either way
			n       = $urandom_range(1, 30);
			step_sz = (2 * limit) >>> n;
			k       = longint'(r % ((longint'(1) << n) + 1));
			return -limit + k * step_sz + longint'($urandom_range(0, 2)) - 1;
		end else if (pick < 95) begin
			return longint'(r);
		end else begin
			return $urandom_range(0, 1) ? limit : -limit;
		end
	endfunction

	// mostly legal lengths, now and then zero or above twelve
	function automatic int pick_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 15);
		return $urandom_range(1, MAX_HASH_CHARS);
	endfunction

	// offer one transaction, hold it until taken, then maybe end the burst
	task automatic offer(input longint lat_v, input longint lon_v, input int len_v);
		int gap;
		coord_ch.valid       <= 1'b1;
		coord_ch.latitude    <= LAT_W'(lat_v);
		coord_ch.longitude   <= LON_W'(lon_v);
		coord_ch.hash_length <= LEN_W'(len_v);
		@(posedge clk);
		while (!coord_ch.ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			// short gaps usually, now and then a long one
			gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
				: $urandom_range(0, 3);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
				: $urandom_range(1, 8);
			if (gap != 0) begin
				coord_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver: random ready patterns, plus one long hold-off once the
	// block has taken a few dozen pairs, to fill its queue and stall the input
	initial begin : sink_side
		sink_mode_t mode;
		int         span, k;
		bit         hold_done;
		hold_done     = 1'b0;
		hash_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 80);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				if (!hold_done && pairs >= HOLD_AFTER) begin
					hash_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					SINK_OPEN:   hash_ch.ready <= 1'b1;
					SINK_COIN:   hash_ch.ready <= $urandom_range(0, 1);
					SINK_SPARSE: hash_ch.ready <= ($urandom_range(0, 3) == 0);
					default:     hash_ch.ready <= (k % 3 != 0);
				endcase
			end
		end
	end

	// sender and verdict
	initial begin : source_side
		int i;
		arst_n               <= 1'b0;
		coord_ch.valid       <= 1'b0;
		coord_ch.latitude    <= '0;
		coord_ch.longitude   <= '0;
		coord_ch.hash_length <= '0;
		burst_left = $urandom_range(1, 8);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: exact midpoints, poles and antimeridian corners
		offer(0, 0, 12);
		offer(LAT_MAX, LON_MAX, 12);
		offer(-LAT_MAX, -LON_MAX, 12);
		offer(LAT_MAX, -LON_MAX, 5);
		offer(-LAT_MAX, LON_MAX, 5);
		// one lsb either side of the poles and of zero
		offer(LAT_MAX - 1, LON_MAX - 1, 12);
		offer(-LAT_MAX + 1, -LON_MAX + 1, 12);
		offer(-1, -1, 12);
		offer(1, 1, 12);
		// saturation: most positive and most negative field patterns
		offer((longint'(1) << (LAT_W - 1)) - 1, (longint'(1) << (LON_W - 1)) - 1, 12);
		offer(-(longint'(1) << (LAT_W - 1)), -(longint'(1) << (LON_W - 1)), 12);
		offer(LAT_MAX + 1, -LON_MAX - 1, 7);
		// length of zero acts as one, lengths past twelve act as twelve
		offer(pick_coord(LAT_MAX), pick_coord(LON_MAX), 0);
		offer(pick_coord(LAT_MAX), pick_coord(LON_MAX), 1);
		offer(pick_coord(LAT_MAX), pick_coord(LON_MAX), 13);
		offer(pick_coord(LAT_MAX), pick_coord(LON_MAX), 15);
		// quarter points sit on second-level boundaries
		offer(LAT_MAX / 2, LON_MAX / 2, 12);
		offer(-LAT_MAX / 2, -LON_MAX / 2, 12);

		// random part
		for (i = 0; i < RANDOM_PAIRS; i++)
			offer(pick_coord(LAT_MAX), pick_coord(LON_MAX), pick_length());
		coord_ch.valid <= 1'b0;

		// let the checker see the last pair, drain, then a quiet tail
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d coordinate pairs encoded, %0d characters compared, %0d mismatches",
			pairs, chars, errors);
		$display("covered poles, antimeridian, cell edges, saturation, all lengths and a %0d-cycle stall",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
